[rtl/gps_pkg.sv]
// Shared types and constants for the granular pitch shifter.
// Used by every module under rtl except gps_ram; depends on nothing else.
`default_nettype none

package gps_pkg;

    // Default sizing
    localparam int BUF_DEPTH_DEF      = 32768;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int WINDOW_ENTRIES_DEF = 1024;

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [2:0] {
        REG_PITCH_RATE   = 3'd0,
        REG_GRAIN_LENGTH = 3'd1,
        REG_DENSITY      = 3'd2,
        REG_INPUT_GAIN   = 3'd3,
        REG_WET_MIX      = 3'd4
    } t_reg_idx;

    // Register reset values
    localparam logic [17:0] PITCH_RST   = 18'd65536;
    localparam logic [14:0] LENGTH_RST  = 15'd2880;
    localparam logic [15:0] DENSITY_RST = 16'd39322;
    localparam logic [16:0] GAIN_RST    = 17'd65536;
    localparam logic [16:0] MIX_RST     = 17'd32768;

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [14:0] MIN_GRAIN = 15'd64;

    // Respawn generator
    localparam logic [31:0] LCG_RST = 32'd305419896;
    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    // Effective settings seen by the datapath
    typedef struct packed {
        logic [17:0] rate;
        logic [14:0] len;
        logic [15:0] density;
        logic [16:0] gain;
        logic [16:0] mix;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic take;
        logic gain;
        logic write;
        logic rd0;
        logic rd1;
        logic interp;
        logic sum;
        logic win;
        logic wet;
        logic wetr;
        logic mix;
        logic phase;
        logic lcg;
        logic sp1;
        logic sp2;
        logic sp3;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic respawn;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

[rtl/gps_ram.sv]
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none

module gps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/gps_cfg.sv]
// APB register file for the pitch shifter settings, with range clamps.
// Depends on gps_pkg.
`default_nettype none

module gps_cfg #(
    parameter int BUF_DEPTH = gps_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [gps_pkg::APB_AW-1:0] paddr,
    input  wire logic [gps_pkg::APB_DW-1:0] pwdata,
    output logic      [gps_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output gps_pkg::t_cfg                   o_cfg
);
    import gps_pkg::*;

    localparam logic [14:0] MAX_GRAIN = 15'(BUF_DEPTH - 4);

    logic [17:0] r_rate;
    logic [14:0] r_len;
    logic [15:0] r_density;
    logic [16:0] r_gain;
    logic [16:0] r_mix;
    t_reg_idx    idx;
    logic        wr_en;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= PITCH_RST;
            r_len     <= LENGTH_RST;
            r_density <= DENSITY_RST;
            r_gain    <= GAIN_RST;
            r_mix     <= MIX_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_PITCH_RATE:   r_rate    <= pwdata[17:0];
                REG_GRAIN_LENGTH: r_len     <= pwdata[14:0];
                REG_DENSITY:      r_density <= pwdata[15:0];
                REG_INPUT_GAIN:   r_gain    <= pwdata[16:0];
                REG_WET_MIX:      r_mix     <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            REG_PITCH_RATE:   prdata = APB_DW'(r_rate);
            REG_GRAIN_LENGTH: prdata = APB_DW'(r_len);
            REG_DENSITY:      prdata = APB_DW'(r_density);
            REG_INPUT_GAIN:   prdata = APB_DW'(r_gain);
            REG_WET_MIX:      prdata = APB_DW'(r_mix);
            default:          prdata = '0;
        endcase
    end

    // Clamp length into the usable range and gains to one
    always_comb begin
        o_cfg.rate    = r_rate;
        o_cfg.density = r_density;
        if (r_len < MIN_GRAIN) begin
            o_cfg.len = MIN_GRAIN;
        end else if (r_len > MAX_GRAIN) begin
            o_cfg.len = MAX_GRAIN;
        end else begin
            o_cfg.len = r_len;
        end
        o_cfg.gain = (r_gain > ONE_Q16) ? ONE_Q16 : r_gain;
        o_cfg.mix  = (r_mix > ONE_Q16) ? ONE_Q16 : r_mix;
    end

endmodule

`default_nettype wire

[rtl/gps_ctrl.sv]
// Sequencer for the pitch shifter: clearing pass, then one request at a time.
// Depends on gps_pkg; drives the datapath through t_cmd, watches t_status.
`default_nettype none

module gps_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire gps_pkg::t_status i_status,
    output gps_pkg::t_cmd         o_cmd
);
    import gps_pkg::*;

    typedef enum logic [19:0] {
        ST_CLEAR  = 20'h00001,
        ST_IDLE   = 20'h00002,
        ST_GAIN   = 20'h00004,
        ST_WRITE  = 20'h00008,
        ST_RD0    = 20'h00010,
        ST_RD1    = 20'h00020,
        ST_INTERP = 20'h00040,
        ST_SUM    = 20'h00080,
        ST_DIVW   = 20'h00100,
        ST_WIN    = 20'h00200,
        ST_WET    = 20'h00400,
        ST_WETR   = 20'h00800,
        ST_MIX    = 20'h01000,
        ST_PHASE  = 20'h02000,
        ST_CHECK  = 20'h04000,
        ST_LCG    = 20'h08000,
        ST_SP1    = 20'h10000,
        ST_SP2    = 20'h20000,
        ST_SP3    = 20'h40000,
        ST_OUT    = 20'h80000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_GAIN;
                end
            end
            ST_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = ST_RD0;
            end
            ST_RD0: begin
                o_cmd.rd0 = 1'b1;
                n_state   = ST_RD1;
            end
            ST_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = ST_INTERP;
            end
            ST_INTERP: begin
                o_cmd.interp = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_DIVW;
            end
            ST_DIVW: begin
                if (i_status.div_done) n_state = ST_WIN;
            end
            ST_WIN: begin
                o_cmd.win = 1'b1;
                n_state   = ST_WET;
            end
            ST_WET: begin
                o_cmd.wet = 1'b1;
                n_state   = ST_WETR;
            end
            ST_WETR: begin
                o_cmd.wetr = 1'b1;
                n_state    = ST_MIX;
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = ST_PHASE;
            end
            ST_PHASE: begin
                o_cmd.phase = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_status.respawn ? ST_LCG : ST_OUT;
            end
            ST_LCG: begin
                o_cmd.lcg = 1'b1;
                n_state   = ST_SP1;
            end
            ST_SP1: begin
                o_cmd.sp1 = 1'b1;
                n_state   = ST_SP2;
            end
            ST_SP2: begin
                o_cmd.sp2 = 1'b1;
                n_state   = ST_SP3;
            end
            ST_SP3: begin
                o_cmd.sp3 = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

[rtl/gps_dp.sv]
// Datapath of the pitch shifter: sample stores, interpolation, window table,
// window index divider, phase and respawn logic, output register.
// Depends on gps_pkg and gps_ram.
`default_nettype none

module gps_dp #(
    parameter int BUF_DEPTH      = gps_pkg::BUF_DEPTH_DEF,
    parameter int SAMPLE_BITS    = gps_pkg::SAMPLE_BITS_DEF,
    parameter int WINDOW_ENTRIES = gps_pkg::WINDOW_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gps_pkg::t_cfg                 i_cfg,
    input  wire gps_pkg::t_cmd                 i_cmd,
    output gps_pkg::t_status                   o_status,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_in,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic signed      [SAMPLE_BITS-1:0] o_left_out,
    output logic signed      [SAMPLE_BITS-1:0] o_right_out
);
    import gps_pkg::*;

    localparam int SB        = SAMPLE_BITS;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int EW        = $clog2(WINDOW_ENTRIES);
    localparam int PW        = AW + 16;
    localparam int SW        = SB + 20;
    localparam int DIV_STEPS = 32 + EW;
    localparam int DCW       = $clog2(DIV_STEPS + 1);

    localparam logic signed [SW-1:0] HALF   = SW'(32768);
    localparam logic signed [SW-1:0] SAT_HI = {21'b0, {(SB-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{21{1'b1}}, {(SB-1){1'b0}}};

    // Hann table, built at elaboration with a Q30 Taylor series for sin
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                              64'd156};

    typedef logic [WINDOW_ENTRIES-1:0][16:0] t_hann_tab;

    function automatic t_hann_tab build_hann();
        t_hann_tab          tab;
        logic [63:0]        a;
        logic [63:0]        t;
        logic [63:0]        j;
        logic [63:0]        sq;
        logic signed [63:0] s;
        for (int i = 0; i < WINDOW_ENTRIES; i++) begin
            j = (i <= WINDOW_ENTRIES - i) ? 64'(i) : 64'(WINDOW_ENTRIES - i);
            a = (PI_Q30 * j) / WINDOW_ENTRIES;
            s = $signed(a);
            t = a;
            for (int k = 0; k < 6; k++) begin
                t = (((t * a) >> 30) * a) >> 30;
                t = t / TAYLOR_DIV[k];
                if (k % 2 == 0) s = s - $signed(t);
                else            s = s + $signed(t);
            end
            if (s < 0) s = 0;
            if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
            sq = ($unsigned(s) * $unsigned(s) + (64'd1 << 43)) >> 44;
            tab[i] = sq[16:0];
        end
        return tab;
    endfunction

    localparam t_hann_tab HANN_TAB = build_hann();

    // Round half up by 2^16, then saturate to the sample range
    function automatic logic signed [SB-1:0] sat_round(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = (v + HALF) >>> 16;
        if (t > SAT_HI)      return SAT_HI[SB-1:0];
        else if (t < SAT_LO) return SAT_LO[SB-1:0];
        else                 return t[SB-1:0];
    endfunction

    // Round half up by 2^16 where the result is known to fit
    function automatic logic signed [SB-1:0] round16(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = (v + HALF) >>> 16;
        return t[SB-1:0];
    endfunction

    // Control and state registers
    logic [AW-1:0]  r_clr;
    logic [AW-1:0]  r_wi;
    logic [31:0]    r_phase;
    logic [31:0]    r_lcg;
    logic [DCW-1:0] r_dcnt;
    logic           r_ov;

    // Payload registers
    logic signed [SB-1:0]    r_xl, r_xr;
    logic signed [SB+17:0]   r_gpl, r_gpr;
    logic signed [SB+17:0]   r_dryl, r_dryr;
    logic [PW-1:0]           r_pos;
    logic signed [SB-1:0]    r_s0l, r_s0r;
    logic signed [SB+17:0]   r_pal, r_par, r_pbl, r_pbr;
    logic signed [SB-1:0]    r_gl, r_gr;
    logic [16:0]             r_win;
    logic signed [SB+17:0]   r_wpl, r_wpr;
    logic signed [SB-1:0]    r_wl, r_wr;
    logic signed [SB+17:0]   r_mpl, r_mpr;
    logic [39:0]             r_rd;
    logic [54:0]             r_sp;
    logic [31:0]             r_rem;
    logic [31:0]             r_dvd;
    logic [EW-1:0]           r_quo;
    logic signed [SB-1:0]    r_ol, r_or;

    // Store ports
    logic                    ram_we;
    logic [AW-1:0]           ram_addr;
    logic [SB-1:0]           wd_l, wd_r;
    logic [SB-1:0]           rd_l, rd_r;

    logic [AW-1:0]           i0, i1;
    logic [15:0]             frac;
    logic [16:0]             omf;
    logic [16:0]             dry;
    logic [31:0]             len_q;
    logic [31:0]             div_t;
    logic                    div_ge;
    logic [30:0]             spawn;
    logic [PW-1:0]           pos_n;

    assign i0    = r_pos[PW-1:16];
    assign i1    = i0 + AW'(1);
    assign frac  = r_pos[15:0];
    assign omf   = ONE_Q16 - {1'b0, frac};
    assign dry   = ONE_Q16 - i_cfg.mix;
    assign len_q = {1'b0, i_cfg.len, 16'b0};
    assign pos_n = {r_wi, 16'b0} - r_phase[PW-1:0];
    assign spawn = r_sp[54:24];

    // One restoring step of the window index divider
    assign div_t  = {r_rem[30:0], r_dvd[31]};
    assign div_ge = (div_t >= len_q);

    // Store address and data
    always_comb begin
        ram_we   = 1'b0;
        ram_addr = r_wi;
        wd_l     = sat_round(SW'(r_gpl));
        wd_r     = sat_round(SW'(r_gpr));
        if (i_cmd.clear) begin
            ram_we   = 1'b1;
            ram_addr = r_clr;
            wd_l     = '0;
            wd_r     = '0;
        end else if (i_cmd.write) begin
            ram_we = 1'b1;
        end else if (i_cmd.rd0) begin
            ram_addr = i0;
        end else if (i_cmd.rd1) begin
            ram_addr = i1;
        end
    end

    gps_ram #(.WIDTH(SB), .DEPTH(BUF_DEPTH)) u_left_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (wd_l),
        .o_rdata (rd_l)
    );

    gps_ram #(.WIDTH(SB), .DEPTH(BUF_DEPTH)) u_right_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (wd_r),
        .o_rdata (rd_r)
    );

    // Clear counter, write index, phase, generator, divider count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_wi    <= '0;
            r_phase <= '0;
            r_lcg   <= LCG_RST;
            r_dcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + AW'(1);
            if (i_cmd.write) begin
                r_dcnt <= DCW'(DIV_STEPS);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - DCW'(1);
            end
            if (i_cmd.phase) r_phase <= r_phase + 32'(i_cfg.rate);
            if (i_cmd.sp3) r_phase <= (spawn >= len_q[30:0]) ? 32'd0 : {1'b0, spawn};
            if (i_cmd.lcg) r_lcg <= r_lcg * LCG_MUL + LCG_ADD;
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
                r_wi <= r_wi + AW'(1);
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_xl <= i_left_in;
            r_xr <= i_right_in;
        end
        if (i_cmd.gain) begin
            r_gpl  <= r_xl * $signed({1'b0, i_cfg.gain});
            r_gpr  <= r_xr * $signed({1'b0, i_cfg.gain});
            r_dryl <= r_xl * $signed({1'b0, dry});
            r_dryr <= r_xr * $signed({1'b0, dry});
        end
        if (i_cmd.write) begin
            r_pos <= pos_n;
            r_dvd <= r_phase;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_dcnt != '0) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= div_ge ? (div_t - len_q) : div_t;
            r_quo <= {r_quo[EW-2:0], div_ge};
        end
        if (i_cmd.rd1) begin
            r_s0l <= $signed(rd_l);
            r_s0r <= $signed(rd_r);
        end
        if (i_cmd.interp) begin
            r_pal <= r_s0l * $signed({1'b0, omf});
            r_par <= r_s0r * $signed({1'b0, omf});
            r_pbl <= $signed(rd_l) * $signed({1'b0, frac});
            r_pbr <= $signed(rd_r) * $signed({1'b0, frac});
        end
        if (i_cmd.sum) begin
            r_gl <= round16(SW'(r_pal) + SW'(r_pbl));
            r_gr <= round16(SW'(r_par) + SW'(r_pbr));
        end
        if (i_cmd.win) r_win <= HANN_TAB[r_quo];
        if (i_cmd.wet) begin
            r_wpl <= r_gl * $signed({1'b0, r_win});
            r_wpr <= r_gr * $signed({1'b0, r_win});
        end
        if (i_cmd.wetr) begin
            r_wl <= round16(SW'(r_wpl));
            r_wr <= round16(SW'(r_wpr));
        end
        if (i_cmd.mix) begin
            r_mpl <= r_wl * $signed({1'b0, i_cfg.mix});
            r_mpr <= r_wr * $signed({1'b0, i_cfg.mix});
        end
        if (i_cmd.sp1) r_rd <= r_lcg[23:0] * i_cfg.density;
        if (i_cmd.sp2) r_sp <= r_rd * i_cfg.len;
        if (i_cmd.load_out) begin
            r_ol <= sat_round(SW'(r_dryl) + SW'(r_mpl));
            r_or <= sat_round(SW'(r_dryr) + SW'(r_mpr));
        end
    end

    assign o_status.clr_last = (r_clr == AW'(BUF_DEPTH - 1));
    assign o_status.div_done = (r_dcnt == '0);
    assign o_status.respawn  = (r_phase >= len_q);
    assign o_status.out_busy = r_ov && !i_out_ready;

    assign o_out_valid = r_ov;
    assign o_left_out  = r_ol;
    assign o_right_out = r_or;

endmodule

`default_nettype wire

[rtl/granular_pitch_shifter.sv]
// Top level of the stereo granular pitch shifter.
// Depends on gps_pkg, gps_cfg, gps_ctrl, gps_dp (and gps_ram below it).
//
//   port group   direction  handshake                       payload
//   input        in         i_in_valid / o_in_ready         i_left_in, i_right_in
//   output       out        o_out_valid / i_out_ready       o_left_out, o_right_out
//   settings     in         psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// After reset a clearing pass zeroes both sample stores with o_in_ready low;
// register writes are taken throughout.
// Each request then runs from acceptance to a loaded result, also through the
// LCG and SP1 to SP3 states when a grain respawns; the controller waits in ST_DIVW
// for the window index divider, which gives one quotient bit a cycle.
// A result waits in the output register while the next request is accepted;
// if it is still not taken, the next result holds in the datapath.
`default_nettype none

module granular_pitch_shifter #(
    parameter int BUF_DEPTH      = gps_pkg::BUF_DEPTH_DEF,
    parameter int SAMPLE_BITS    = gps_pkg::SAMPLE_BITS_DEF,
    parameter int WINDOW_ENTRIES = gps_pkg::WINDOW_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed      [SAMPLE_BITS-1:0] o_left_out,
    output logic signed      [SAMPLE_BITS-1:0] o_right_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gps_pkg::APB_AW-1:0]    paddr,
    input  wire logic [gps_pkg::APB_DW-1:0]    pwdata,
    output logic      [gps_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);
    import gps_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    gps_cfg #(.BUF_DEPTH(BUF_DEPTH)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gps_dp #(
        .BUF_DEPTH      (BUF_DEPTH),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .WINDOW_ENTRIES (WINDOW_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

endmodule

`default_nettype wire
